[design/pof_pkg.sv]
// ----------------------------------------------------------------------------
// pof_pkg
// shared constants and types of the pattern occurrence finder
// ----------------------------------------------------------------------------
package pof_pkg;

  localparam int unsigned PATTERN_MAX_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;

  localparam int unsigned LEN_W      = 5;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [7:0]        DROP_BYTE = 8'hC3;
  localparam logic [OUT_W-1:0]  COUNT_MAX = {OUT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH    = 2'd0,
    CFG_PATTERN_WORD_LOW  = 2'd1,
    CFG_PATTERN_WORD_HIGH = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] match_start;
    logic [OUT_W-1:0] match_end;
    logic [OUT_W-1:0] match_total;
    logic             end_of_text;
  } result_t;

  typedef struct packed {
    logic accept;
    logic keep;
    logic last;
  } beat_ctrl_t;

endpackage

[design/pof_cell.sv]
// ----------------------------------------------------------------------------
// pof_cell
// one window byte: shifts from its neighbor and compares against its pattern byte
// ----------------------------------------------------------------------------
module pof_cell
  import pof_pkg::*;
#(
  parameter int unsigned PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int unsigned IDX         = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  beat_ctrl_t       ctrl_i,
  input  logic [7:0]       byte_i,
  output logic [7:0]       byte_o,
  input  logic [7:0]       pattern_i [PATTERN_MAX],
  input  logic [LEN_W-1:0] len_i,
  output logic             hit_o
);

  localparam int unsigned IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [7:0]       byte_q, byte_d;
  logic             active;
  logic [LEN_W-1:0] sel_full;
  logic [IDX_W-1:0] sel;

  assign active   = (LEN_W'(IDX) < len_i);
  assign sel_full = active ? (len_i - LEN_W'(1) - LEN_W'(IDX)) : '0;
  assign sel      = sel_full[IDX_W-1:0];
  assign hit_o    = !active || (byte_i == pattern_i[sel]);

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.accept && ctrl_i.last) begin
      byte_d = '0;
    end else if (ctrl_i.accept && ctrl_i.keep) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

[design/pof_tracker.sv]
// ----------------------------------------------------------------------------
// pof_tracker
// text position, last match end and occurrence count; decides each result
// ----------------------------------------------------------------------------
module pof_tracker
  import pof_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             drop_i,
  input  logic             last_i,
  input  logic             window_hit_i,
  input  logic [LEN_W-1:0] len_i,
  output logic             keep_o,
  output logic             emit_o,
  output result_t          result_o
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] prev_end_q, prev_end_d;
  logic [OUT_W-1:0]         count_q, count_d;
  logic [POSITION_BITS-1:0] pos_new, len_ext, start_pos;
  logic                     keep, enough, found;
  logic [OUT_W-1:0]         total;

  assign keep      = !drop_i && (pos_q != POS_MAX);
  assign pos_new   = pos_q + POSITION_BITS'(1);
  assign len_ext   = POSITION_BITS'(len_i);
  assign enough    = (len_i != '0) && (pos_new >= len_ext);
  assign start_pos = pos_new - len_ext + POSITION_BITS'(1);
  assign found     = keep && window_hit_i && enough && ((pos_new - len_ext) >= prev_end_q);
  assign total     = (found && (count_q != COUNT_MAX)) ? count_q + OUT_W'(1) : count_q;

  always_comb begin
    pos_d      = pos_q;
    prev_end_d = prev_end_q;
    count_d    = count_q;
    if (accept_i) begin
      if (last_i) begin
        pos_d      = '0;
        prev_end_d = '0;
        count_d    = '0;
      end else begin
        if (keep) begin
          pos_d = pos_new;
        end
        if (found) begin
          prev_end_d = pos_new;
        end
        count_d = total;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      prev_end_q <= '0;
      count_q    <= '0;
    end else begin
      pos_q      <= pos_d;
      prev_end_q <= prev_end_d;
      count_q    <= count_d;
    end
  end

  assign keep_o = keep;
  assign emit_o = found || last_i;

  always_comb begin
    result_o.found       = found;
    result_o.match_start = found ? OUT_W'(start_pos) : '0;
    result_o.match_end   = found ? OUT_W'(pos_new) : '0;
    result_o.match_total = total;
    result_o.end_of_text = last_i;
  end

endmodule

[design/pattern_occurrence_finder_core.sv]
// Finds every non-overlapping occurrence of a pattern of up to PATTERN_MAX
// bytes in a byte stream. One text byte is taken per clock cycle while the
// output is not stalled; its result appears on the output register in the
// next cycle. That rate is set by the window cells, which shift and compare
// all pattern bytes in parallel in the cycle the byte is taken. Bytes 0xC3
// are dropped and take no position. A result beat is sent only when a byte
// completes an occurrence or carries tlast; tlast ends the text and clears
// the window, position and count. Pattern registers are kept across texts.
// ----------------------------------------------------------------------------
// pattern_occurrence_finder_core
// streaming exact pattern matcher built from a chain of window cells
// ----------------------------------------------------------------------------
module pattern_occurrence_finder_core
  import pof_pkg::*;
#(
  parameter int unsigned PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // text stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // text_byte
  input  logic                  s_axis_tlast,   // text_last
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,   // match_start, match_end, match_total
  output logic                  m_axis_tuser,   // found
  output logic                  m_axis_tlast    // end_of_text
);

  logic [LEN_W-1:0]      len_q;
  logic [CFG_DATA_W-1:0] word_low_q, word_high_q;
  logic [LEN_W-1:0]      len_eff;
  logic [7:0]            pattern [PATTERN_MAX];
  logic [7:0]            chain   [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] hits;

  beat_ctrl_t ctrl;
  logic       accept, keep, emit;
  result_t    result;
  result_t    out_q;
  logic       out_valid_q, out_valid_d;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= LEN_W'(1);
      word_low_q  <= '0;
      word_high_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH:    len_q       <= cfg_data_i[LEN_W-1:0];
        CFG_PATTERN_WORD_LOW:  word_low_q  <= cfg_data_i;
        CFG_PATTERN_WORD_HIGH: word_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign len_eff = (len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_q;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    if (k < 8) begin : g_low
      assign pattern[k] = word_low_q[8*k +: 8];
    end else begin : g_high
      assign pattern[k] = word_high_q[8*(k-8) +: 8];
    end
  end

  // input handshake and output register
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ctrl.accept = accept;
  assign ctrl.keep   = keep;
  assign ctrl.last   = s_axis_tlast;

  assign chain[0] = s_axis_tdata;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    pof_cell #(
      .PATTERN_MAX (PATTERN_MAX),
      .IDX         (j)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .byte_i    (chain[j]),
      .byte_o    (chain[j+1]),
      .pattern_i (pattern),
      .len_i     (len_eff),
      .hit_o     (hits[j])
    );
  end

  pof_tracker #(
    .POSITION_BITS (POSITION_BITS)
  ) u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .drop_i       (s_axis_tdata == DROP_BYTE),
    .last_i       (s_axis_tlast),
    .window_hit_i (&hits),
    .len_i        (len_eff),
    .keep_o       (keep),
    .emit_o       (emit),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.match_total, out_q.match_end, out_q.match_start};
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tlast  = out_q.end_of_text;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming pattern occurrence finder: a local
// match predictor tracks the window, position, last match end and count for
// every accepted text beat, and each result beat is compared field by field
// with the oldest predicted beat; directed cases and random texts with
// embedded pattern copies run under changing back pressure
// ----------------------------------------------------------------------------
module tb_top;
  import pof_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned POS_MAX        = 65535;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;  // text_byte
  logic                  s_axis_tlast  = 1'b0; // text_last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [47:0]           m_axis_tdata;        // match_start, match_end, match_total
  logic                  m_axis_tuser;        // found
  logic                  m_axis_tlast;        // end_of_text

  // predictor state
  logic [7:0]            window_bytes [PATTERN_MAX_DEF];
  int unsigned           text_pos;
  int unsigned           last_match_end;
  logic [OUT_W-1:0]      match_count;
  logic [LEN_W-1:0]      pattern_len = LEN_W'(1);
  logic [CFG_DATA_W-1:0] pattern_lo  = '0;
  logic [CFG_DATA_W-1:0] pattern_hi  = '0;
  logic [7:0]            text_symbols [2];

  result_t               pending_matches [$];
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;
  int unsigned           error_count   = 0;
  int unsigned           text_beats    = 0;
  int unsigned           result_beats  = 0;
  int unsigned           match_beats   = 0;
  int unsigned           reg_writes    = 0;
  int unsigned           quiet_cycles  = 0;

  pattern_occurrence_finder_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void clear_text_state();
    foreach (window_bytes[i]) window_bytes[i] = 8'h00;
    text_pos       = 0;
    last_match_end = 0;
    match_count    = '0;
  endfunction

  function automatic logic [7:0] pattern_byte(int unsigned k);
    if (k < 8) return pattern_lo[8*k +: 8];
    return pattern_hi[8*(k-8) +: 8];
  endfunction

  function automatic void predict_match(logic [7:0] b, logic l);
    result_t     r;
    int unsigned len;
    int unsigned first;
    logic        hit;
    r   = '0;
    hit = 1'b0;
    if (b != DROP_BYTE && text_pos < POS_MAX) begin
      for (int i = PATTERN_MAX_DEF - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
      window_bytes[0] = b;
      text_pos++;
      len = (pattern_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pattern_len;
      hit = (len != 0) && (text_pos >= len);
      for (int k = 0; k < len; k++) begin
        if (window_bytes[len-1-k] != pattern_byte(k)) hit = 1'b0;
      end
      if (hit) begin
        first = text_pos - len + 1;
        if (first > last_match_end) begin
          r.found       = 1'b1;
          r.match_start = OUT_W'(first);
          r.match_end   = OUT_W'(text_pos);
          last_match_end = text_pos;
          if (match_count != COUNT_MAX) match_count++;
        end
      end
    end
    if (r.found || l) begin
      r.match_total = match_count;
      r.end_of_text = l;
      pending_matches.push_back(r);
    end
    if (l) clear_text_state();
  endfunction

  task automatic check_field(string name, logic [OUT_W-1:0] expected, logic [OUT_W-1:0] actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_checker
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_beats++;
      if (pending_matches.size() == 0) begin
        $error("result beat with no match pending");
        error_count++;
      end else begin
        want = pending_matches.pop_front();
        if (want.found) match_beats++;
        check_field("found", OUT_W'(want.found), OUT_W'(m_axis_tuser));
        check_field("match_start", want.match_start, m_axis_tdata[15:0]);
        check_field("match_end", want.match_end, m_axis_tdata[31:16]);
        check_field("match_total", want.match_total, m_axis_tdata[47:32]);
        check_field("end_of_text", OUT_W'(want.end_of_text), OUT_W'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** pattern_occurrence_finder_core: FAILED **");
      $finish;
    end
  end

  task automatic push_text_byte(logic [7:0] b, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_match(b, l);
    text_beats++;
  endtask

  task automatic write_pattern_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (cfg_index_e'(idx))
      CFG_PATTERN_LENGTH:    pattern_len = data[LEN_W-1:0];
      CFG_PATTERN_WORD_LOW:  pattern_lo  = data;
      CFG_PATTERN_WORD_HIGH: pattern_hi  = data;
      default: ;
    endcase
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop the text stream and let the block run empty
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_default_pattern();
    push_text_byte(8'h00, 1'b0);
    push_text_byte(DROP_BYTE, 1'b0);
    push_text_byte(8'h00, 1'b0);
    push_text_byte(8'hFF, 1'b1);
  endtask

  task automatic test_non_overlap();
    logic [CFG_DATA_W-1:0] word;
    word = {$urandom, $urandom};
    word[15:0] = 16'h4141;
    settle_block();
    write_pattern_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(2));
    write_pattern_reg(CFG_PATTERN_WORD_LOW, word);
    push_text_byte(8'h41, 1'b0);
    push_text_byte(DROP_BYTE, 1'b0);
    push_text_byte(8'h41, 1'b0);
    push_text_byte(8'h41, 1'b0);
    push_text_byte(8'h41, 1'b1);
  endtask

  task automatic test_length_zero();
    logic [CFG_DATA_W-1:0] word;
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = '0;
    settle_block();
    write_pattern_reg(CFG_PATTERN_LENGTH, word);
    write_pattern_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
    push_text_byte(8'h41, 1'b0);
    push_text_byte(8'h41, 1'b1);
  endtask

  task automatic test_length_above_max();
    settle_block();
    write_pattern_reg(CFG_PATTERN_LENGTH, {CFG_DATA_W{1'b1}});
    write_pattern_reg(CFG_PATTERN_WORD_LOW, 64'h0123_4567_89AB_CDEF);
    write_pattern_reg(CFG_PATTERN_WORD_HIGH, 64'hFF00_7F80_1E2D_3C4B);
    for (int k = 0; k < PATTERN_MAX_DEF; k++) begin
      push_text_byte(pattern_byte(k), k == PATTERN_MAX_DEF - 1);
    end
  endtask

  // a dropped byte in the pattern never matches, a dropped last byte still ends the text
  task automatic test_dropped_pattern_byte();
    settle_block();
    write_pattern_reg(CFG_PATTERN_LENGTH, CFG_DATA_W'(1));
    write_pattern_reg(CFG_PATTERN_WORD_LOW, CFG_DATA_W'(DROP_BYTE));
    write_pattern_reg(CFG_PATTERN_WORD_HIGH, '0);
    push_text_byte(DROP_BYTE, 1'b0);
    push_text_byte(DROP_BYTE, 1'b1);
  endtask

  task automatic configure_random_pattern();
    logic [7:0]            pat [PATTERN_MAX_DEF];
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    int unsigned           roll;
    int unsigned           new_len;
    roll = $urandom_range(99);
    if (roll < 4) new_len = 0;
    else if (roll < 12) new_len = $urandom_range(31, 17);
    else if (roll < 24) new_len = $urandom_range(16, 9);
    else new_len = $urandom_range(6, 1);
    text_symbols[0] = ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(255));
    text_symbols[1] = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
    foreach (pat[k]) pat[k] = text_symbols[$urandom_range(1)];
    if ($urandom_range(19) == 0) pat[$urandom_range(PATTERN_MAX_DEF - 1)] = DROP_BYTE;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pat[k];
      hi[8*k +: 8] = pat[k+8];
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      lo = '1;
      hi = '1;
      text_symbols[0] = 8'hFF;
    end else if (roll < 6) begin
      lo = '0;
      hi = '0;
      text_symbols[1] = 8'h00;
    end
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = LEN_W'(new_len);
    write_pattern_reg(CFG_PATTERN_LENGTH, len_word);
    write_pattern_reg(CFG_PATTERN_WORD_LOW, lo);
    if (new_len > 8 || $urandom_range(1) == 0) write_pattern_reg(CFG_PATTERN_WORD_HIGH, hi);
  endtask

  // texts built mostly from pattern copies and near misses, with dropped bytes mixed in
  task automatic test_random_texts(int unsigned n_beats);
    logic [7:0]  text_q [$];
    int unsigned sent;
    int unsigned eff_len;
    int unsigned target;
    int unsigned roll;
    int unsigned cut;
    logic        hold_open;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(99) < 40) begin
        settle_block();
        configure_random_pattern();
      end
      text_q.delete();
      eff_len = (pattern_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : pattern_len;
      target  = ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4);
      while (text_q.size() < target) begin
        roll = $urandom_range(99);
        if (roll < 45) begin
          for (int k = 0; k < eff_len; k++) text_q.push_back(pattern_byte(k));
        end else if (roll < 55) begin
          cut = (eff_len > 1) ? $urandom_range(eff_len - 1, 1) : 0;
          for (int k = 0; k < cut; k++) text_q.push_back(pattern_byte(k));
        end else if (roll < 62) begin
          text_q.push_back(DROP_BYTE);
        end else if (roll < 90) begin
          text_q.push_back(text_symbols[$urandom_range(1)]);
        end else begin
          text_q.push_back(8'($urandom_range(255)));
        end
      end
      hold_open = ($urandom_range(9) == 0);
      foreach (text_q[i]) push_text_byte(text_q[i], (i == text_q.size() - 1) && !hold_open);
      sent += text_q.size();
    end
  endtask

  initial begin
    clear_text_state();
    text_symbols[0] = 8'h41;
    text_symbols[1] = 8'h42;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(27, 85);
    test_default_pattern();
    test_non_overlap();
    test_length_zero();
    test_length_above_max();
    test_dropped_pattern_byte();
    test_random_texts(600);
    set_idling(85, 27);
    test_random_texts(600);
    set_idling(0, 0);
    test_random_texts(600);
    settle_block();

    $display("run covered %0d text beats, %0d result beats (%0d matches), %0d register writes",
             text_beats, result_beats, match_beats, reg_writes);
    $display("pattern lengths 0 to 31, dropped bytes, overlap rejection, stalls on both sides");
    if (error_count == 0 && pending_matches.size() == 0) begin
      $display("** pattern_occurrence_finder_core: PASSED **");
    end else begin
      $display("** pattern_occurrence_finder_core: FAILED **");
    end
    $finish;
  end

endmodule
